### hdl/sliding_window_hit_counter_top_defines.svh
// Assertion macros used by the top block to check its own logic.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SLIDING_WINDOW_HIT_COUNTER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_HIT_COUNTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWHC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sliding window hit counter check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sliding window hit counter check failed");

`endif

### hdl/swhc_pkg.sv
`timescale 1ns / 1ps

package swhc_pkg;

  localparam int unsigned DepthDefault = 1024;
  localparam int unsigned StampW       = 31;
  localparam int unsigned WindowW      = 16;
  localparam int unsigned HitCountW    = 11;

  localparam logic [WindowW-1:0]   WindowReset = 16'd300;
  localparam logic [HitCountW-1:0] CountMax    = 11'd2047;

  localparam logic OpHit   = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [StampW-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [HitCountW-1:0] hit_count;
    logic                 overflow;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  typedef enum logic {
    StIdle,
    StExpire
  } state_e;

endpackage

### hdl/sliding_window_hit_counter_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Payload                        | Handshake
// in      | input     | in_item_t (operation, stamp)   | in_valid_i / in_stall_o
// out     | output    | out_item_t (count, overflow)   | out_valid_o / out_stall_i
// cfg     | input     | window_length, 16 bits         | cfg_we_i
//
// A hit item gives no result. A query item moves the block into the expire state,
// where the row of cells pops one expired entry a cycle while any is left; then the
// result goes to the output register. Reset clears the fill level, the overflow flag
// and the window to 300; the cells themselves are not cleared. Input is stalled
// while a query expires entries or its result waits for a free output register.

module sliding_window_hit_counter_top #(
  parameter int unsigned DEPTH = swhc_pkg::DepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  swhc_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output swhc_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [swhc_pkg::WindowW-1:0]    cfg_data_i
);

  `include "sliding_window_hit_counter_top_defines.svh"

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned ExtW = (CntW > swhc_pkg::HitCountW) ? CntW : swhc_pkg::HitCountW;

  swhc_pkg::state_e state_q, state_d;

  logic [CntW-1:0]                count_q, count_d;
  logic                           overflow_q, overflow_d;
  logic [swhc_pkg::WindowW-1:0]   window_q;
  logic [swhc_pkg::StampW-1:0]    now_q;
  logic                           out_valid_q, out_valid_d;
  swhc_pkg::out_item_t            out_item_q;

  logic [swhc_pkg::StampW-1:0]    cell_data [DEPTH];
  swhc_pkg::cell_ctrl_t           ctrl;

  logic                           accept, full, out_free, out_load, drop;
  logic                           head_old, expire_hit;
  logic [swhc_pkg::StampW:0]      diff;
  logic [swhc_pkg::StampW-1:0]    age;
  logic [ExtW-1:0]                count_ext;
  logic [swhc_pkg::HitCountW-1:0] hit_count;

  // Row of cells; cell 0 holds the oldest stamp.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [swhc_pkg::StampW-1:0] next_data;
    if (i == DEPTH - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end
    swhc_cell #(
      .Index (i),
      .CntW  (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .push_data_i (in_item_i.timestamp),
      .next_data_i (next_data),
      .data_o      (cell_data[i])
    );
  end

  // A stamp newer than the query time has age zero.
  assign diff = {1'b0, now_q} - {1'b0, cell_data[0]};
  assign age  = diff[swhc_pkg::StampW] ? '0 : diff[swhc_pkg::StampW-1:0];
  assign head_old   = (age >= swhc_pkg::StampW'(window_q));
  assign expire_hit = (count_q != '0) && head_old;

  assign full     = (count_q == CntW'(DEPTH));
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swhc_pkg::StIdle: begin
        if (accept && in_item_i.operation == swhc_pkg::OpQuery) begin
          state_d = swhc_pkg::StExpire;
        end
      end
      swhc_pkg::StExpire: begin
        if (!expire_hit && out_free) begin
          state_d = swhc_pkg::StIdle;
        end
      end
      default: state_d = swhc_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ctrl       = '0;
    drop       = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      swhc_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i && in_item_i.operation == swhc_pkg::OpHit) begin
          ctrl.push = !full;
          drop      = full;
        end
      end
      swhc_pkg::StExpire: begin
        ctrl.pop = expire_hit;
        out_load = !expire_hit && out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign overflow_d = overflow_q || drop;

  assign count_ext = ExtW'(count_q);
  assign hit_count = (count_ext > ExtW'(swhc_pkg::CountMax)) ? swhc_pkg::CountMax
                                                             : count_ext[swhc_pkg::HitCountW-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swhc_pkg::StIdle;
      count_q     <= '0;
      overflow_q  <= 1'b0;
      window_q    <= swhc_pkg::WindowReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      overflow_q  <= overflow_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= in_item_i.timestamp;
    end
    if (out_load) begin
      out_item_q.hit_count <= hit_count;
      out_item_q.overflow  <= overflow_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `SWHC_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CntW'(DEPTH))
  `SWHC_ASSERT_SAME(a_accept_idle, accept, state_q == swhc_pkg::StIdle)
  `SWHC_ASSERT_SAME(a_pop_nonempty, ctrl.pop, count_q != '0 && !ctrl.push)
  `SWHC_ASSERT_NEXT(a_result_shown, out_load, out_valid_q && state_q == swhc_pkg::StIdle)

endmodule

### hdl/swhc_cell.sv
`timescale 1ns / 1ps

module swhc_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 11
) (
  input  logic                           clk_i,
  input  swhc_pkg::cell_ctrl_t           ctrl_i,
  input  logic [CntW-1:0]                count_i,
  input  logic [swhc_pkg::StampW-1:0]    push_data_i,
  input  logic [swhc_pkg::StampW-1:0]    next_data_i,
  output logic [swhc_pkg::StampW-1:0]    data_o
);

  logic [swhc_pkg::StampW-1:0] data_q, data_d;
  logic                        is_tail;

  // The first free cell sits at the current fill level.
  assign is_tail = (count_i == CntW'(Index));

  always_comb begin
    data_d = data_q;
    if (ctrl_i.pop) begin
      data_d = next_data_i;
    end else if (ctrl_i.push && is_tail) begin
      data_d = push_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
